// ----- src/symmetric_3x3_blur_top_defines.svh -----
// assertion macros shared by the 3x3 blur modules
`ifndef SYMMETRIC_3X3_BLUR_TOP_DEFINES_SVH
`define SYMMETRIC_3X3_BLUR_TOP_DEFINES_SVH

// condition holds at every clock edge out of reset
`define S3BLUR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define S3BLUR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/s3blur_pkg.sv -----
// shared constants and types of the symmetric 3x3 blur
package s3blur_pkg;

    localparam int IMAGE_WIDTH_DEF  = 128;
    localparam int IMAGE_HEIGHT_DEF = 128;
    localparam int SAMPLE_BITS_DEF  = 20;

    localparam int SAMPLE_IN_W = 20;
    localparam int S_TDATA_W   = 24;
    localparam int WEIGHT_W    = 24;
    localparam int RESULT_W    = 48;
    localparam int POS_W       = 7;
    localparam int M_TDATA_W   = 64;
    localparam int M_PAD_W     = M_TDATA_W - RESULT_W - 2 * POS_W;
    localparam int NUM_TAPS    = 9;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CORNER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_EDGE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CENTRE = 2'd2;

    // 1.0 in signed Q7.16
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET = 24'sd65536;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } win_ctrl_t;

endpackage

// ----- src/symmetric_3x3_blur_top.sv -----
// top level of the symmetric 3x3 blur over a raster sample stream
//
// s_ channel: one sample per request in raster order; s_tuser[0] marks the
//   first sample of a frame and restarts the row and column counters.
// m_ channel: one request per interior window centre (row and column both
//   between 1 and size-2); border positions give no request. m_tlast marks
//   the last interior centre of the frame.
// cfg channel: writes the corner, edge and centre weights (signed Q7.16),
//   always ready; write only while the block holds no sample in flight.
// Throughput: one sample per cycle while the output is not stalled. Path: the
//   sample completing a window goes through the line store read stage, the
//   group sum stage and the multiply into the output register to m_tvalid.
// Reset: weights go to 1.0, the counters to row 0 column 0, the pipeline
//   empties. The line stores need no clearing: the first two rows of a frame
//   fill every column before any window reads them.
// When m_tready is low the result holds in the output register; the sum and
//   window stages keep taking samples until they are full, then s_tready drops.
module symmetric_3x3_blur_top #(
    parameter int IMAGE_WIDTH  = s3blur_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = s3blur_pkg::IMAGE_HEIGHT_DEF,
    parameter int SAMPLE_BITS  = s3blur_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [s3blur_pkg::S_TDATA_W-1:0]     s_tdata,    // sample[19:0], zero pad
    input  logic [0:0]                           s_tuser,    // frame_start
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [s3blur_pkg::M_TDATA_W-1:0]     m_tdata,    // filtered_value[47:0],
                                                             // centre_row[54:48],
                                                             // centre_col[61:55], zero pad
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [s3blur_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [s3blur_pkg::WEIGHT_W-1:0]      cfg_data
);

    logic signed [s3blur_pkg::WEIGHT_W-1:0] weight_corner_reg;
    logic signed [s3blur_pkg::WEIGHT_W-1:0] weight_edge_reg;
    logic signed [s3blur_pkg::WEIGHT_W-1:0] weight_centre_reg;

    logic [SAMPLE_BITS-1:0]         sample_in;
    logic [SAMPLE_BITS-1:0]         taps [s3blur_pkg::NUM_TAPS];
    s3blur_pkg::win_ctrl_t          win_ctrl;
    logic                           win_ready;
    logic signed [s3blur_pkg::RESULT_W-1:0] out_value;
    logic [s3blur_pkg::POS_W-1:0]   out_row, out_col;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_corner_reg <= s3blur_pkg::WEIGHT_RESET;
            weight_edge_reg   <= s3blur_pkg::WEIGHT_RESET;
            weight_centre_reg <= s3blur_pkg::WEIGHT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                s3blur_pkg::CFG_WEIGHT_CORNER: begin
                    weight_corner_reg <= $signed(cfg_data);
                end
                s3blur_pkg::CFG_WEIGHT_EDGE: begin
                    weight_edge_reg <= $signed(cfg_data);
                end
                s3blur_pkg::CFG_WEIGHT_CENTRE: begin
                    weight_centre_reg <= $signed(cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    assign sample_in = SAMPLE_BITS'(s_tdata[s3blur_pkg::SAMPLE_IN_W-1:0]);

    s3blur_window #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_window (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_sample      (sample_in),
        .in_frame_start (s_tuser[0]),
        .taps           (taps),
        .ctrl           (win_ctrl),
        .win_ready      (win_ready)
    );

    s3blur_kernel #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_kernel (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .taps          (taps),
        .ctrl          (win_ctrl),
        .win_ready     (win_ready),
        .weight_corner (weight_corner_reg),
        .weight_edge   (weight_edge_reg),
        .weight_centre (weight_centre_reg),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .m_value       (out_value),
        .m_row         (out_row),
        .m_col         (out_col),
        .m_last        (m_tlast)
    );

    assign m_tdata = {{s3blur_pkg::M_PAD_W{1'b0}}, out_col, out_row, out_value};

endmodule

// ----- src/s3blur_ram.sv -----
// generic single-write, single-read ram with registered read data
module s3blur_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/s3blur_window.sv -----
// raster position tracking, two line stores and the 3x3 window register
`include "symmetric_3x3_blur_top_defines.svh"

module s3blur_window #(
    parameter int IMAGE_WIDTH  = s3blur_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = s3blur_pkg::IMAGE_HEIGHT_DEF,
    parameter int SAMPLE_BITS  = s3blur_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic                   in_frame_start,
    output logic [SAMPLE_BITS-1:0] taps [s3blur_pkg::NUM_TAPS],
    output s3blur_pkg::win_ctrl_t  ctrl,
    input  logic                   win_ready
);

    localparam int COL_W = $clog2(IMAGE_WIDTH);
    localparam int ROW_W = $clog2(IMAGE_HEIGHT);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMAGE_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMAGE_HEIGHT - 1);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic             accept;

    logic                   s1_valid_reg, s1_valid_next;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [COL_W-1:0]       s1_col_reg;
    logic [ROW_W-1:0]       s1_row_reg;
    logic                   byp_reg;
    logic [SAMPLE_BITS-1:0] byp_top_reg, byp_mid_reg;
    logic [SAMPLE_BITS-1:0] upper_rdata, middle_rdata;
    logic [SAMPLE_BITS-1:0] s1_top, s1_mid;
    logic                   s1_hit, s1_advance;

    // columns c-2 (top, mid, bottom) then c-1 (top, mid, bottom)
    logic [SAMPLE_BITS-1:0] win_reg [6];

    assign accept  = in_valid && in_ready;
    assign cur_col = in_frame_start ? '0 : col_reg;
    assign cur_row = in_frame_start ? '0 : row_reg;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (cur_col == COL_LAST) begin
                col_next = '0;
                row_next = (cur_row == ROW_LAST) ? '0 : cur_row + ROW_W'(1);
            end else begin
                col_next = cur_col + COL_W'(1);
                row_next = cur_row;
            end
        end
    end

    // line store read data lines up with stage one
    assign s1_top = byp_reg ? byp_top_reg : upper_rdata;
    assign s1_mid = byp_reg ? byp_mid_reg : middle_rdata;

    assign s1_hit     = (s1_row_reg >= ROW_W'(2)) && (s1_col_reg >= COL_W'(2));
    assign s1_advance = s1_valid_reg && (!s1_hit || win_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    assign s1_valid_next = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_sample_reg <= in_sample;
            s1_col_reg    <= cur_col;
            s1_row_reg    <= cur_row;
            // same column written this cycle: the ram read returns stale data
            byp_reg       <= s1_advance && (cur_col == s1_col_reg);
            byp_top_reg   <= s1_mid;
            byp_mid_reg   <= s1_sample_reg;
        end
        if (s1_advance) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= s1_top;
            win_reg[4] <= s1_mid;
            win_reg[5] <= s1_sample_reg;
        end
    end

    s3blur_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (IMAGE_WIDTH)
    ) u_upper (
        .aclk  (aclk),
        .we    (s1_advance),
        .waddr (s1_col_reg),
        .wdata (s1_mid),
        .re    (accept),
        .raddr (cur_col),
        .rdata (upper_rdata)
    );

    s3blur_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (IMAGE_WIDTH)
    ) u_middle (
        .aclk  (aclk),
        .we    (s1_advance),
        .waddr (s1_col_reg),
        .wdata (s1_sample_reg),
        .re    (accept),
        .raddr (cur_col),
        .rdata (middle_rdata)
    );

    // row-major taps, top-left first
    assign taps[0] = win_reg[0];
    assign taps[1] = win_reg[3];
    assign taps[2] = s1_top;
    assign taps[3] = win_reg[1];
    assign taps[4] = win_reg[4];
    assign taps[5] = s1_mid;
    assign taps[6] = win_reg[2];
    assign taps[7] = win_reg[5];
    assign taps[8] = s1_sample_reg;

    assign ctrl.valid = s1_valid_reg && s1_hit;
    assign ctrl.row   = s3blur_pkg::POS_W'(s1_row_reg - ROW_W'(1));
    assign ctrl.col   = s3blur_pkg::POS_W'(s1_col_reg - COL_W'(1));
    assign ctrl.last  = (s1_row_reg == ROW_LAST) && (s1_col_reg == COL_LAST);

    `S3BLUR_ASSERT_ALWAYS(a_pos_range, (col_reg <= COL_LAST) && (row_reg <= ROW_LAST), "position out of range")
    `S3BLUR_ASSERT_NEXT(a_col_step, accept && !in_frame_start && (col_reg != COL_LAST), col_reg == $past(col_reg) + COL_W'(1), "column did not advance")
    `S3BLUR_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_advance, s1_valid_reg && $stable(s1_col_reg) && $stable(s1_sample_reg), "stalled window stage changed")

endmodule

// ----- src/s3blur_kernel.sv -----
// weighted 3x3 sum: group sums, then the three products into the output register
`include "symmetric_3x3_blur_top_defines.svh"

module s3blur_kernel #(
    parameter int SAMPLE_BITS = s3blur_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic [SAMPLE_BITS-1:0]                    taps [s3blur_pkg::NUM_TAPS],
    input  s3blur_pkg::win_ctrl_t                     ctrl,
    output logic                                      win_ready,
    input  logic signed [s3blur_pkg::WEIGHT_W-1:0]    weight_corner,
    input  logic signed [s3blur_pkg::WEIGHT_W-1:0]    weight_edge,
    input  logic signed [s3blur_pkg::WEIGHT_W-1:0]    weight_centre,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic signed [s3blur_pkg::RESULT_W-1:0]    m_value,
    output logic [s3blur_pkg::POS_W-1:0]              m_row,
    output logic [s3blur_pkg::POS_W-1:0]              m_col,
    output logic                                      m_last
);

    localparam int SUM_W  = SAMPLE_BITS + 2;
    localparam int PROD_W = s3blur_pkg::WEIGHT_W + SUM_W + 1;
    localparam int TOT_W  = PROD_W + 2;

    logic                  s2_valid_reg;
    logic [SUM_W-1:0]      corner_sum_reg, edge_sum_reg;
    logic [SAMPLE_BITS-1:0] centre_reg;
    logic [s3blur_pkg::POS_W-1:0] s2_row_reg, s2_col_reg;
    logic                  s2_last_reg;

    logic                  out_valid_reg;
    logic signed [s3blur_pkg::RESULT_W-1:0] value_reg;
    logic [s3blur_pkg::POS_W-1:0] row_reg, col_reg;
    logic                  last_reg;

    logic                  out_ready, s2_advance, win_take;
    logic signed [PROD_W-1:0] prod_corner, prod_edge, prod_centre;
    logic signed [TOT_W-1:0]  total;

    assign out_ready  = !out_valid_reg || m_ready;
    assign s2_advance = s2_valid_reg && out_ready;
    assign win_ready  = !s2_valid_reg || out_ready;
    assign win_take   = ctrl.valid && win_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (win_take) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_advance) begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (win_take) begin
            corner_sum_reg <= SUM_W'(taps[0]) + SUM_W'(taps[2])
                            + SUM_W'(taps[6]) + SUM_W'(taps[8]);
            edge_sum_reg   <= SUM_W'(taps[1]) + SUM_W'(taps[3])
                            + SUM_W'(taps[5]) + SUM_W'(taps[7]);
            centre_reg     <= taps[4];
            s2_row_reg     <= ctrl.row;
            s2_col_reg     <= ctrl.col;
            s2_last_reg    <= ctrl.last;
        end
        if (s2_advance) begin
            value_reg <= s3blur_pkg::RESULT_W'(total);
            row_reg   <= s2_row_reg;
            col_reg   <= s2_col_reg;
            last_reg  <= s2_last_reg;
        end
    end

    // sums are unsigned, so a zero bit goes on top before the signed multiply
    assign prod_corner = PROD_W'(weight_corner) * PROD_W'($signed({1'b0, corner_sum_reg}));
    assign prod_edge   = PROD_W'(weight_edge) * PROD_W'($signed({1'b0, edge_sum_reg}));
    assign prod_centre = PROD_W'(weight_centre) * PROD_W'($signed({1'b0, centre_reg}));
    assign total       = TOT_W'(prod_corner) + TOT_W'(prod_edge) + TOT_W'(prod_centre);

    assign m_valid = out_valid_reg;
    assign m_value = value_reg;
    assign m_row   = row_reg;
    assign m_col   = col_reg;
    assign m_last  = last_reg;

    `S3BLUR_ASSERT_NEXT(a_win_taken, win_take, s2_valid_reg, "window request not captured")
    `S3BLUR_ASSERT_NEXT(a_out_load, s2_advance, out_valid_reg, "sum stage did not reach output")

endmodule

// ----- tb/blur_checker.sv -----
// result checker for the 3x3 blur: raster window prediction and field compare
module blur_checker
    import s3blur_pkg::*;
#(
    parameter int IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [WEIGHT_W-1:0]   cfg_data,
    output int                    mismatch_count,
    output int                    windows_pending
);

    typedef struct packed {
        logic [RESULT_W-1:0] value;
        logic [POS_W-1:0]    row;
        logic [POS_W-1:0]    col;
        logic                last;
    } window_sum_t;

    logic signed [WEIGHT_W-1:0] wt_corner;
    logic signed [WEIGHT_W-1:0] wt_nbr;
    logic signed [WEIGHT_W-1:0] wt_ctr;

    logic [SAMPLE_IN_W-1:0] upper_line [IMAGE_WIDTH];
    logic [SAMPLE_IN_W-1:0] middle_line [IMAGE_WIDTH];
    // two previous columns: top, mid, bottom of column c-2, then of column c-1
    logic [SAMPLE_IN_W-1:0] taps [6];
    int row_pos;
    int col_pos;

    window_sum_t expected_sums [$];

    task automatic advance_raster(input logic [SAMPLE_IN_W-1:0] px, input logic frame_start);
        logic [SAMPLE_IN_W-1:0] above2;
        logic [SAMPLE_IN_W-1:0] above1;
        longint corners;
        longint sides;
        longint full;
        window_sum_t win;
        if (frame_start) begin
            row_pos = 0;
            col_pos = 0;
        end
        above2 = upper_line[col_pos];
        above1 = middle_line[col_pos];
        if (row_pos >= 2 && col_pos >= 2) begin
            corners = longint'(taps[0]) + longint'(taps[2]) + longint'(above2) + longint'(px);
            sides = longint'(taps[1]) + longint'(taps[3]) + longint'(taps[5]) + longint'(above1);
            full = longint'(wt_corner) * corners + longint'(wt_nbr) * sides
                 + longint'(wt_ctr) * longint'(taps[4]);
            win.value = full[RESULT_W-1:0];
            win.row = POS_W'(row_pos - 1);
            win.col = POS_W'(col_pos - 1);
            win.last = (row_pos == IMAGE_HEIGHT - 1) && (col_pos == IMAGE_WIDTH - 1);
            expected_sums.push_back(win);
        end
        taps[0] = taps[3];
        taps[1] = taps[4];
        taps[2] = taps[5];
        taps[3] = above2;
        taps[4] = above1;
        taps[5] = px;
        upper_line[col_pos] = above1;
        middle_line[col_pos] = px;
        col_pos++;
        if (col_pos >= IMAGE_WIDTH) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= IMAGE_HEIGHT)
                row_pos = 0;
        end
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] tdata, input logic tlast);
        window_sum_t want;
        logic [RESULT_W-1:0] got_value;
        logic [POS_W-1:0] got_row;
        logic [POS_W-1:0] got_col;
        got_value = tdata[RESULT_W-1:0];
        got_row = tdata[RESULT_W +: POS_W];
        got_col = tdata[RESULT_W + POS_W +: POS_W];
        if (expected_sums.size() == 0) begin
            $error("unexpected result: filtered_value %0d centre_row %0d centre_col %0d",
                   $signed(got_value), got_row, got_col);
            mismatch_count++;
        end else begin
            want = expected_sums.pop_front();
            if (got_value !== want.value) begin
                $error("filtered_value: expected %0d, got %0d",
                       $signed(want.value), $signed(got_value));
                mismatch_count++;
            end
            if (got_row !== want.row) begin
                $error("centre_row: expected %0d, got %0d", want.row, got_row);
                mismatch_count++;
            end
            if (got_col !== want.col) begin
                $error("centre_col: expected %0d, got %0d", want.col, got_col);
                mismatch_count++;
            end
            if (tlast !== want.last) begin
                $error("frame_last: expected %0d, got %0d", want.last, tlast);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            wt_corner = WEIGHT_RESET;
            wt_nbr = WEIGHT_RESET;
            wt_ctr = WEIGHT_RESET;
            for (int i = 0; i < IMAGE_WIDTH; i++) begin
                upper_line[i] = '0;
                middle_line[i] = '0;
            end
            for (int i = 0; i < 6; i++)
                taps[i] = '0;
            row_pos = 0;
            col_pos = 0;
            expected_sums.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WEIGHT_CORNER: wt_corner = cfg_data;
                    CFG_WEIGHT_EDGE:   wt_nbr = cfg_data;
                    CFG_WEIGHT_CENTRE: wt_ctr = cfg_data;
                    default: ;
                endcase
            end
            // a result can never come from a sample taken at the same edge
            if (m_tvalid && m_tready)
                check_result(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                advance_raster(s_tdata[SAMPLE_IN_W-1:0], s_tuser[0]);
        end
        windows_pending = expected_sums.size();
    end

endmodule

// ----- tb/testbench.sv -----
// testbench top for the 3x3 blur: clock, reset, raster stimulus and verdict
module testbench;
    import s3blur_pkg::*;

    localparam int CYCLE_LIMIT   = 40000;
    localparam int SETTLE_CYCLES = 8;
    localparam int ROW_LEN       = IMAGE_WIDTH_DEF;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [SAMPLE_IN_W-1:0] SAMPLE_MAX = '1;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 24'sh7FFFFF;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 24'sh800000;

    typedef enum int {
        FILL_RANDOM,
        FILL_FULL,
        FILL_ZERO,
        FILL_LOW,
        FILL_NEAR_MAX
    } fill_mode_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;     // sample[19:0], zero pad
    logic [0:0]             s_tuser;     // frame_start
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;     // filtered_value[47:0], centre_row[54:48],
                                         // centre_col[61:55], zero pad
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [WEIGHT_W-1:0]    cfg_data;

    int mismatch_count;
    int windows_pending;
    int tx_idle_pct = 7;
    int rx_idle_pct = 54;
    int samples_sent = 0;
    int cycle_count;

    symmetric_3x3_blur_top DUT (.*);

    blur_checker window_check (.*);

    always #10 aclk = ~aclk;

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    // starts and ends at a falling edge, with s_tvalid left high
    task automatic send_sample(input logic [SAMPLE_IN_W-1:0] px, input logic frame_start);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'(px);
        s_tuser <= frame_start;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        samples_sent++;
    endtask

    function automatic logic [SAMPLE_IN_W-1:0] pick_sample(input fill_mode_t mode);
        case (mode)
            FILL_FULL:     return SAMPLE_MAX;
            FILL_ZERO:     return '0;
            FILL_LOW:      return SAMPLE_IN_W'($urandom_range(15));
            FILL_NEAR_MAX: return SAMPLE_MAX - SAMPLE_IN_W'($urandom_range(15));
            default:       return SAMPLE_IN_W'($urandom);
        endcase
    endfunction

    // one raster run; content style changes once per row length
    task automatic send_run(input int count, input bit open_frame, input bit noisy);
        fill_mode_t mode;
        logic fs;
        mode = FILL_RANDOM;
        for (int i = 0; i < count; i++) begin
            if (i % ROW_LEN == 0)
                mode = ($urandom_range(1) == 0) ? FILL_RANDOM
                                                : fill_mode_t'($urandom_range(FILL_NEAR_MAX));
            fs = (i == 0 && open_frame) || (noisy && $urandom_range(299) == 0);
            send_sample(pick_sample(mode), fs);
        end
    endtask

    task automatic random_phase(input int budget);
        int goal;
        goal = samples_sent + budget;
        while (samples_sent < goal)
            send_run($urandom_range(2 * ROW_LEN + 8, 3 * ROW_LEN),
                     $urandom_range(4) != 0, 1'b1);
    endtask

    // hold off the sender until every result is back and the pipe has drained
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (windows_pending != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic load_weights(input logic [WEIGHT_W-1:0] corner_w,
                                input logic [WEIGHT_W-1:0] nbr_w,
                                input logic [WEIGHT_W-1:0] ctr_w,
                                input bit poke_unused);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [WEIGHT_W-1:0] val [4];
        int n;
        idx = '{CFG_WEIGHT_CORNER, CFG_WEIGHT_EDGE, CFG_WEIGHT_CENTRE, CFG_UNUSED};
        val = '{corner_w, nbr_w, ctr_w, WEIGHT_W'($urandom)};
        n = poke_unused ? 4 : 3;
        for (int k = 0; k < n; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= val[k];
            @(posedge aclk);
            while (!cfg_ready)
                @(posedge aclk);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // counters run from reset with no frame start
        send_sample('0, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(20'h55555, 1'b0);
        send_sample(20'hAAAAA, 1'b0);
        // frame start mid-row, then twice in a row
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample('0, 1'b0);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(20'h00001, 1'b1);
        send_sample(20'h80000, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample('0, 1'b0);
        send_sample(20'h7FFFF, 1'b0);

        // reset weights, then all at the positive extreme
        random_phase(250);
        wait_idle();
        load_weights(WEIGHT_MAX, WEIGHT_MAX, WEIGHT_MAX, 1'b0);
        random_phase(250);
        wait_idle();

        tx_idle_pct = 54;
        rx_idle_pct = 7;
        load_weights(WEIGHT_MIN, WEIGHT_MAX, '0, 1'b1);
        random_phase(250);
        wait_idle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_weights(WEIGHT_W'($urandom), WEIGHT_W'($urandom), WEIGHT_W'($urandom), 1'b0);
        random_phase(250);
        wait_idle();

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
